@@ sv/utf8d_pkg.sv @@
// Package: result beat type, lead octet decode and completed value check for the UTF-8 decoder.
package utf8d_pkg;

   // one result beat as it sits in the output queue
   typedef struct packed {
      logic [30:0] code_point;
      logic        error;
      logic        last;
   } result_type;

   // class of an octet taken as the start of a sequence
   typedef enum logic [1:0] {
      LEAD_ASCII,
      LEAD_MULTI,
      LEAD_BAD
   } lead_kind_type;

   typedef struct packed {
      lead_kind_type kind;
      logic [2:0]    trailers;
      logic [30:0]   load;
   } lead_type;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [30:0] SURR_LO = 31'h0000_D800;
   localparam logic [30:0] SURR_HI = 31'h0000_DFFF;
   localparam logic [30:0] NONCH_E = 31'h0000_FFFE;
   localparam logic [30:0] NONCH_F = 31'h0000_FFFF;

   // classify a lead octet and place its payload bits at their final position
   function automatic lead_type decode_lead(input logic [7:0] c);
      lead_type r;
      r.kind     = LEAD_BAD;
      r.trailers = 3'd0;
      r.load     = 31'd0;
      priority if (c[7] == 1'b0) begin
         r.kind = LEAD_ASCII;
         r.load = 31'(c);
      end else if (c[7:5] == 3'b110) begin
         r.kind     = LEAD_MULTI;
         r.trailers = 3'd1;
         r.load     = 31'({c[4:0], 6'd0});
      end else if (c[7:4] == 4'b1110) begin
         r.kind     = LEAD_MULTI;
         r.trailers = 3'd2;
         r.load     = 31'({c[3:0], 12'd0});
      end else if (c[7:3] == 5'b11110) begin
         r.kind     = LEAD_MULTI;
         r.trailers = 3'd3;
         r.load     = 31'({c[2:0], 18'd0});
      end else if (c[7:2] == 6'b111110) begin
         r.kind     = LEAD_MULTI;
         r.trailers = 3'd4;
         r.load     = 31'({c[1:0], 24'd0});
      end else if (c[7:1] == 7'b1111110) begin
         r.kind     = LEAD_MULTI;
         r.trailers = 3'd5;
         r.load     = {c[0], 30'd0};
      end else begin
         r.kind = LEAD_BAD;
      end
      return r;
   endfunction

   // place six continuation bits below those already gathered
   function automatic logic [30:0] place_trailer(input logic [5:0] bits,
                                                 input logic [2:0] pos);
      logic [30:0] r;
      unique case (pos)
         3'd0:    r = 31'(bits);
         3'd1:    r = 31'({bits, 6'd0});
         3'd2:    r = 31'({bits, 12'd0});
         3'd3:    r = 31'({bits, 18'd0});
         3'd4:    r = 31'({bits, 24'd0});
         default: r = 31'd0;
      endcase
      return r;
   endfunction

   // reject overlong forms, surrogates and the two noncharacters
   function automatic logic bad_value(input logic [30:0] v, input logic [2:0] len);
      logic overlong;
      unique case (len)
         3'd1:    overlong = (v < 31'h0000_0080);
         3'd2:    overlong = (v < 31'h0000_0800);
         3'd3:    overlong = (v < 31'h0001_0000);
         3'd4:    overlong = (v < 31'h0020_0000);
         3'd5:    overlong = (v < 31'h0400_0000);
         default: overlong = 1'b0;
      endcase
      return overlong || ((v >= SURR_LO) && (v <= SURR_HI)) ||
             (v == NONCH_E) || (v == NONCH_F);
   endfunction

endpackage

@@ sv/utf8_stream_decoder_top.sv @@
// Top level: UTF-8 byte stream decoder with a four-beat result queue.
//
// Input channel req_: one octet per beat on req_byte_in, valid/ready handshake.
// Result channel rsp_: code point, error flag and last flag per beat.
// Each octet yields zero, one or two results; last marks the final result that
// an octet causes. An octet that breaks a sequence gives an error beat and is
// then decoded as a new lead, so it may give a second beat.
// Decode is one short pass on the accepted octet and the sequence state; the
// results are registered only in the result queue, and each is offered from
// the head of that queue.
// Throughput: one octet per cycle while the receiver takes one beat per cycle and
// each octet gives at most one result; an octet with two results gives two beats.
// req_ready is high while the queue has room for two beats, so a stalled
// receiver holds back the input once the queue fills; nothing is dropped.
// Reset (synchronous, active high) clears the sequence state and empties the
// queue; both channels are held off while it is high. A sequence left
// incomplete at the end of the stream is never flushed.
module utf8_stream_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [30:0] rsp_code_point,
   output logic        rsp_error,
   output logic        rsp_last
);

   localparam int unsigned AW = utf8d_pkg::QUEUE_AW;

   // sequence state
   logic [2:0]  trailers_ff, trailers_in;
   logic [2:0]  seqlen_ff, seqlen_in;
   logic [30:0] acc_ff, acc_in;

   // result queue
   utf8d_pkg::result_type queue_ff [utf8d_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;

   logic                  accept, pop;
   logic [1:0]            n_res;
   utf8d_pkg::result_type res0, res1;
   utf8d_pkg::lead_type   ld;
   logic [2:0]            trailers_eff, trailers_dec;
   logic [30:0]           acc_merged;
   logic                  reject;

   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = !reset && (count_ff <= (AW+1)'(utf8d_pkg::QUEUE_DEPTH - 2));
   assign rsp_valid = !reset && (count_ff != '0);

   assign rsp_code_point = queue_ff[rd_ptr_ff].code_point;
   assign rsp_error      = queue_ff[rd_ptr_ff].error;
   assign rsp_last       = queue_ff[rd_ptr_ff].last;

   // classify the octet both as a lead and as a continuation
   assign ld           = utf8d_pkg::decode_lead(req_byte_in);
   assign trailers_eff = (trailers_ff > 3'd5) ? 3'd0 : trailers_ff;
   assign trailers_dec = trailers_eff - 3'd1;
   assign acc_merged   = acc_ff | utf8d_pkg::place_trailer(req_byte_in[5:0], trailers_dec);
   assign reject       = utf8d_pkg::bad_value(acc_merged, seqlen_ff);

   // decode the accepted octet into up to two results and the next state
   always_comb begin
      trailers_in = trailers_ff;
      seqlen_in   = seqlen_ff;
      acc_in      = acc_ff;
      n_res       = 2'd0;
      res0        = '{code_point: 31'd0, error: 1'b1, last: 1'b1};
      res1        = '{code_point: 31'd0, error: 1'b1, last: 1'b1};
      if (accept) begin
         if (trailers_eff != 3'd0 && req_byte_in[7:6] == 2'b10) begin
            // continuation: add six bits, finish on the last one
            trailers_in = trailers_dec;
            acc_in      = acc_merged;
            if (trailers_dec == 3'd0) begin
               n_res = 2'd1;
               if (reject) begin
                  acc_in = 31'd0;
               end else begin
                  res0.code_point = acc_merged;
                  res0.error      = 1'b0;
               end
            end
         end else begin
            // lead octet or broken sequence: error beat first if broken, then decode as a lead
            logic       broken;
            logic [1:0] slot;
            broken = (trailers_eff != 3'd0);
            slot   = broken ? 2'd1 : 2'd0;
            if (broken) begin
               res0.last = 1'b0;
               acc_in    = 31'd0;
            end
            unique case (ld.kind)
               utf8d_pkg::LEAD_ASCII: begin
                  trailers_in = 3'd0;
                  seqlen_in   = 3'd0;
                  acc_in      = ld.load;
                  n_res       = slot + 2'd1;
                  if (broken) begin
                     res1.code_point = ld.load;
                     res1.error      = 1'b0;
                  end else begin
                     res0.code_point = ld.load;
                     res0.error      = 1'b0;
                  end
               end
               utf8d_pkg::LEAD_MULTI: begin
                  trailers_in = ld.trailers;
                  seqlen_in   = ld.trailers;
                  acc_in      = ld.load;
                  n_res       = slot;
                  res0.last   = 1'b1;
               end
               default: begin
                  trailers_in = 3'd0;
                  acc_in      = 31'd0;
                  n_res       = slot + 2'd1;
               end
            endcase
         end
      end
   end

   // advance the queue pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff + AW'(n_res);
      rd_ptr_in = pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (AW+1)'(n_res) - (AW+1)'(pop);
   end

   // hold control state; clear on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         trailers_ff <= 3'd0;
         seqlen_ff   <= 3'd0;
         acc_ff      <= 31'd0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         trailers_ff <= trailers_in;
         seqlen_ff   <= seqlen_in;
         acc_ff      <= acc_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   // write result beats into the queue
   always_ff @(posedge clock) begin
      if (n_res != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (n_res == 2'd2) begin
         queue_ff[wr_ptr_ff + AW'(1)] <= res1;
      end
   end

endmodule
